FILE: hdl/tmbo_pkg.sv
// ----------------------------------------------------------------------------
// tmbo_pkg
// Shared types and constants of the triangle mesh box overlap core.
// ----------------------------------------------------------------------------
package tmbo_pkg;

    localparam int NUM_PAIRS   = 12;
    localparam int PAIR_BITS   = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int CTL_BITS    = 2;
    localparam int NUM_COORDS  = 10;

    typedef logic [PAIR_BITS-1:0] pair_idx_t;

    localparam pair_idx_t LAST_PAIR = pair_idx_t'(NUM_PAIRS - 1);

    typedef logic [1:0] edge_sel_t;

    localparam edge_sel_t TRI_AB = 2'd0;
    localparam edge_sel_t TRI_BC = 2'd1;
    localparam edge_sel_t TRI_CA = 2'd2;

    localparam edge_sel_t BOX_BOTTOM = 2'd0;
    localparam edge_sel_t BOX_RIGHT  = 2'd1;
    localparam edge_sel_t BOX_TOP    = 2'd2;
    localparam edge_sel_t BOX_LEFT   = 2'd3;

    typedef struct packed {
        logic last_tri;
        logic vert_in;
    } item_ctl_t;

    typedef struct packed {
        logic      last_pair;
        item_ctl_t ctl;
    } pair_tag_t;

endpackage

FILE: hdl/tmbo_if.sv
// ----------------------------------------------------------------------------
// tmbo_if
// Valid/ready channels for triangle items and for query results.
// ----------------------------------------------------------------------------
interface tmbo_item_if #(parameter int COORD_BITS = 20);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic                         last_triangle;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, box_min_x, box_min_y, box_max_x,
               box_max_y, last_triangle,
        input  ready
    );

    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
               vertex_c_x, vertex_c_y, box_min_x, box_min_y, box_max_x,
               box_max_y, last_triangle,
        output ready
    );
endinterface

interface tmbo_result_if;
    logic valid;
    logic ready;
    logic collides;

    modport source (output valid, collides, input ready);
    modport sink (input valid, collides, output ready);
endinterface

FILE: hdl/tmbo_front.sv
// ----------------------------------------------------------------------------
// tmbo_front
// Accepts triangle items, runs the vertex-in-box test and packs each item
// for the work queue.
// ----------------------------------------------------------------------------
module tmbo_front #(
    parameter int COORD_BITS = 20,
    parameter int ITEM_W     = 202
) (
    tmbo_item_if.sink          item_in,
    input  logic               queue_full,
    output logic               push,
    output logic [ITEM_W-1:0]  push_data
);

    tmbo_pkg::item_ctl_t ctl;
    logic                in_a;
    logic                in_b;
    logic                in_c;

    always_comb
    begin
        in_a = (item_in.vertex_a_x >= item_in.box_min_x) &&
               (item_in.vertex_a_x <= item_in.box_max_x) &&
               (item_in.vertex_a_y >= item_in.box_min_y) &&
               (item_in.vertex_a_y <= item_in.box_max_y);
        in_b = (item_in.vertex_b_x >= item_in.box_min_x) &&
               (item_in.vertex_b_x <= item_in.box_max_x) &&
               (item_in.vertex_b_y >= item_in.box_min_y) &&
               (item_in.vertex_b_y <= item_in.box_max_y);
        in_c = (item_in.vertex_c_x >= item_in.box_min_x) &&
               (item_in.vertex_c_x <= item_in.box_max_x) &&
               (item_in.vertex_c_y >= item_in.box_min_y) &&
               (item_in.vertex_c_y <= item_in.box_max_y);
        ctl.vert_in  = in_a || in_b || in_c;
        ctl.last_tri = item_in.last_triangle;
    end

    assign item_in.ready = !queue_full;
    assign push          = item_in.valid && !queue_full;
    assign push_data     = {item_in.vertex_a_x, item_in.vertex_a_y,
                            item_in.vertex_b_x, item_in.vertex_b_y,
                            item_in.vertex_c_x, item_in.vertex_c_y,
                            item_in.box_min_x, item_in.box_min_y,
                            item_in.box_max_x, item_in.box_max_y, ctl};

endmodule

FILE: hdl/tmbo_queue.sv
// ----------------------------------------------------------------------------
// tmbo_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module tmbo_queue #(
    parameter int WIDTH = 202
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_BITS = (tmbo_pkg::QUEUE_DEPTH > 1) ?
                              $clog2(tmbo_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(tmbo_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    data_reg [tmbo_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        if (p == PTR_BITS'(tmbo_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign full       = (count_reg == CNT_BITS'(tmbo_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: hdl/tmbo_back.sv
// ----------------------------------------------------------------------------
// tmbo_back
// Tests every triangle edge of each queued triangle against every box edge
// through one pipelined cross-product unit and accumulates the query result.
// ----------------------------------------------------------------------------
module tmbo_back #(
    parameter int COORD_BITS = 20,
    parameter int ITEM_W     = 202
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  logic [ITEM_W-1:0] head_data,
    output logic              pop,
    tmbo_result_if.source     result_out
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         diff_t;
    typedef logic signed [PW-1:0]         prod_t;
    typedef logic signed [CW-1:0]         cross_t;

    coord_t ax, ay, bx, by, cx, cy, minx, miny, maxx, maxy;
    coord_t p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
    tmbo_pkg::item_ctl_t head_ctl;
    tmbo_pkg::edge_sel_t tri_sel;
    tmbo_pkg::edge_sel_t box_sel;

    logic                en;
    logic                issue;
    tmbo_pkg::pair_idx_t pair_idx_reg;
    tmbo_pkg::pair_idx_t pair_idx_next;

    logic                valid1_reg, valid2_reg, valid3_reg;
    tmbo_pkg::pair_tag_t tag1_reg, tag2_reg, tag3_reg;
    tmbo_pkg::pair_tag_t tag0;
    diff_t               rx_reg, ry_reg, sx_reg, sy_reg, qx_reg, qy_reg;
    prod_t               rxsy_reg, rysx_reg, qxsy_reg, qysx_reg, qxry_reg, qyrx_reg;
    cross_t              rxs_reg, tn_reg, un_reg;

    logic                pair_hit;
    logic                total_hit;
    logic                item_acc_reg, item_acc_next;
    logic                hit_so_far_reg, hit_so_far_next;
    logic                out_valid_reg, out_valid_next;
    logic                collides_reg, collides_next;

    assign ax       = head_data[ITEM_W-1                -: COORD_BITS];
    assign ay       = head_data[ITEM_W-1 - COORD_BITS   -: COORD_BITS];
    assign bx       = head_data[ITEM_W-1 - 2*COORD_BITS -: COORD_BITS];
    assign by       = head_data[ITEM_W-1 - 3*COORD_BITS -: COORD_BITS];
    assign cx       = head_data[ITEM_W-1 - 4*COORD_BITS -: COORD_BITS];
    assign cy       = head_data[ITEM_W-1 - 5*COORD_BITS -: COORD_BITS];
    assign minx     = head_data[ITEM_W-1 - 6*COORD_BITS -: COORD_BITS];
    assign miny     = head_data[ITEM_W-1 - 7*COORD_BITS -: COORD_BITS];
    assign maxx     = head_data[ITEM_W-1 - 8*COORD_BITS -: COORD_BITS];
    assign maxy     = head_data[ITEM_W-1 - 9*COORD_BITS -: COORD_BITS];
    assign head_ctl = head_data[tmbo_pkg::CTL_BITS-1:0];

    assign tri_sel = pair_idx_reg[3:2];
    assign box_sel = pair_idx_reg[1:0];

    // The whole back end freezes while a finished result waits to be taken.
    assign en    = !out_valid_reg || result_out.ready;
    assign issue = en && head_valid;
    assign pop   = issue && (pair_idx_reg == tmbo_pkg::LAST_PAIR);

    always_comb
    begin
        case (tri_sel)
            tmbo_pkg::TRI_AB:
            begin
                p1x = ax; p1y = ay; p2x = bx; p2y = by;
            end
            tmbo_pkg::TRI_BC:
            begin
                p1x = bx; p1y = by; p2x = cx; p2y = cy;
            end
            default:
            begin
                p1x = cx; p1y = cy; p2x = ax; p2y = ay;
            end
        endcase
        case (box_sel)
            tmbo_pkg::BOX_BOTTOM:
            begin
                q1x = minx; q1y = miny; q2x = maxx; q2y = miny;
            end
            tmbo_pkg::BOX_RIGHT:
            begin
                q1x = maxx; q1y = miny; q2x = maxx; q2y = maxy;
            end
            tmbo_pkg::BOX_TOP:
            begin
                q1x = maxx; q1y = maxy; q2x = minx; q2y = maxy;
            end
            default:
            begin
                q1x = minx; q1y = maxy; q2x = minx; q2y = miny;
            end
        endcase
        tag0.last_pair = (pair_idx_reg == tmbo_pkg::LAST_PAIR);
        tag0.ctl       = head_ctl;
    end

    always_comb
    begin
        pair_idx_next = pair_idx_reg;
        if (issue)
            pair_idx_next = pop ? '0 : pair_idx_reg + 1'b1;
    end

    always_comb
    begin
        if (rxs_reg > 0)
            pair_hit = (tn_reg >= 0) && (tn_reg <= rxs_reg) &&
                       (un_reg >= 0) && (un_reg <= rxs_reg);
        else if (rxs_reg < 0)
            pair_hit = (tn_reg >= rxs_reg) && (tn_reg <= 0) &&
                       (un_reg >= rxs_reg) && (un_reg <= 0);
        else
            pair_hit = 1'b0;
    end

    always_comb
    begin
        total_hit       = item_acc_reg || pair_hit || tag3_reg.ctl.vert_in || hit_so_far_reg;
        item_acc_next   = item_acc_reg;
        hit_so_far_next = hit_so_far_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        collides_next   = collides_reg;
        if (en && valid3_reg)
        begin
            if (tag3_reg.last_pair)
            begin
                item_acc_next = 1'b0;
                if (tag3_reg.ctl.last_tri)
                begin
                    hit_so_far_next = 1'b0;
                    out_valid_next  = 1'b1;
                    collides_next   = total_hit;
                end
                else
                begin
                    hit_so_far_next = total_hit;
                end
            end
            else
            begin
                item_acc_next = item_acc_reg || pair_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_idx_reg   <= '0;
            valid1_reg     <= 1'b0;
            valid2_reg     <= 1'b0;
            valid3_reg     <= 1'b0;
            item_acc_reg   <= 1'b0;
            hit_so_far_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pair_idx_reg   <= pair_idx_next;
            item_acc_reg   <= item_acc_next;
            hit_so_far_reg <= hit_so_far_next;
            out_valid_reg  <= out_valid_next;
            if (en)
            begin
                valid1_reg <= issue;
                valid2_reg <= valid1_reg;
                valid3_reg <= valid2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        collides_reg <= collides_next;
        if (en)
        begin
            tag1_reg <= tag0;
            rx_reg   <= diff_t'(p2x) - diff_t'(p1x);
            ry_reg   <= diff_t'(p2y) - diff_t'(p1y);
            sx_reg   <= diff_t'(q2x) - diff_t'(q1x);
            sy_reg   <= diff_t'(q2y) - diff_t'(q1y);
            qx_reg   <= diff_t'(q1x) - diff_t'(p1x);
            qy_reg   <= diff_t'(q1y) - diff_t'(p1y);

            tag2_reg <= tag1_reg;
            rxsy_reg <= prod_t'(rx_reg) * prod_t'(sy_reg);
            rysx_reg <= prod_t'(ry_reg) * prod_t'(sx_reg);
            qxsy_reg <= prod_t'(qx_reg) * prod_t'(sy_reg);
            qysx_reg <= prod_t'(qy_reg) * prod_t'(sx_reg);
            qxry_reg <= prod_t'(qx_reg) * prod_t'(ry_reg);
            qyrx_reg <= prod_t'(qy_reg) * prod_t'(rx_reg);

            tag3_reg <= tag2_reg;
            rxs_reg  <= cross_t'(rxsy_reg) - cross_t'(rysx_reg);
            tn_reg   <= cross_t'(qxsy_reg) - cross_t'(qysx_reg);
            un_reg   <= cross_t'(qxry_reg) - cross_t'(qyrx_reg);
        end
    end

    assign result_out.valid    = out_valid_reg;
    assign result_out.collides = collides_reg;

    a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
        pair_idx_reg <= tmbo_pkg::LAST_PAIR)
        else $error("Pair index ran past the last edge pair.");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (head_valid && pair_idx_reg == tmbo_pkg::LAST_PAIR))
        else $error("Queue popped before all edge pairs were issued.");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(valid3_reg && tag3_reg.last_pair &&
                                       tag3_reg.ctl.last_tri && en))
        else $error("Result appeared without a finished last triangle.");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid3_reg && tag3_reg.last_pair) |=> !item_acc_reg)
        else $error("Per-item hit accumulator not cleared at item end.");

endmodule

FILE: hdl/triangle_mesh_box_overlap_core.sv
// ----------------------------------------------------------------------------
// triangle_mesh_box_overlap_core
// Narrow-phase overlap test of a triangle mesh against an axis-aligned box.
//
// Channel     Dir  Payload
// item_in     in   three vertices, box corners, last_triangle
// result_out  out  collides, one item per query on the last triangle
//
// Each triangle issues its edge pairs (each edge against each box edge) to the
// crossing unit one at a time, and the next triangle starts once the last pair of the current one is issued.
// The result passes the queue, the difference, product and cross-term stages
// and the result register before it is offered.
// A two-entry queue lets the front accept while the back is busy.
// A waiting result freezes the back end until it is taken.
// Reset clears the queue, the pipeline and the running hit flag.
// ----------------------------------------------------------------------------
module triangle_mesh_box_overlap_core #(
    parameter int COORD_BITS = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    tmbo_item_if.sink     item_in,
    tmbo_result_if.source result_out
);

    localparam int ITEM_W = tmbo_pkg::NUM_COORDS * COORD_BITS + tmbo_pkg::CTL_BITS;

    logic              push;
    logic [ITEM_W-1:0] push_data;
    logic              queue_full;
    logic              pop;
    logic              head_valid;
    logic [ITEM_W-1:0] head_data;

    tmbo_front #(
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .item_in    (item_in),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    tmbo_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    tmbo_back #(
        .COORD_BITS (COORD_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule
